@@ design/fps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame protocol statistics package
// Shared widths, header byte positions, match values and the per-frame
// classification record that passes from the parser to the counter bank.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int MAX_FRAME_BYTES = 1518;
    localparam int COUNTER_BITS    = 32;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int OFS_W           = 7;
    localparam int NUM_FIELDS      = 9;
    localparam int NUM_COUNTERS    = 10;

    // Indexes into the latched header byte array.
    localparam int F_ETH_HI = 0;
    localparam int F_ETH_LO = 1;
    localparam int F_ARP_OP = 2;
    localparam int F_VHL    = 3;
    localparam int F_PROTO  = 4;
    localparam int F_ICMP   = 5;
    localparam int F_PORT   = 6;
    localparam int F_LEN_HI = 7;
    localparam int F_LEN_LO = 8;

    // Byte positions within the frame.
    localparam int POS_ETH_HI   = 12;
    localparam int POS_ETH_LO   = 13;
    localparam int POS_VHL      = 14;
    localparam int POS_LEN_HI   = 16;
    localparam int POS_LEN_LO   = 17;
    localparam int POS_ARP_OP   = 21;
    localparam int POS_PROTO    = 23;
    localparam int PORT_LO_SKIP = 3;

    // Values that the latched bytes are compared against.
    localparam logic [7:0] ETH_TYPE_HI    = 8'h08;
    localparam logic [7:0] ETH_LO_ARP     = 8'h06;
    localparam logic [7:0] ETH_LO_IPV4    = 8'h00;
    localparam logic [7:0] ARP_OP_REQUEST = 8'h01;
    localparam logic [7:0] PROTO_ICMP     = 8'h01;
    localparam logic [7:0] PROTO_TCP      = 8'h06;
    localparam logic [7:0] PROTO_UDP      = 8'h11;
    localparam logic [7:0] ICMP_ECHO_REQ  = 8'h08;
    localparam logic [7:0] ICMP_ECHO_REP  = 8'h00;
    localparam logic [7:0] HTTP_PORT_LO   = 8'h50;

    // Counter slots.
    localparam int C_FRAMES    = 0;
    localparam int C_ARP       = 1;
    localparam int C_ARP_REQ   = 2;
    localparam int C_ARP_REP   = 3;
    localparam int C_ICMP      = 4;
    localparam int C_ECHO_REQ  = 5;
    localparam int C_ECHO_REP  = 6;
    localparam int C_TCP       = 7;
    localparam int C_UDP       = 8;
    localparam int C_HTTP      = 9;

    typedef logic [COUNTER_BITS-1:0] counter_t;

    typedef struct packed {
        logic        arp;
        logic        arp_request;
        logic        arp_reply;
        logic        icmp;
        logic        echo_request;
        logic        echo_reply;
        logic        tcp;
        logic        udp;
        logic        http;
        logic [15:0] total_length;
    } frame_class_t;

endpackage

@@ design/fps_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame protocol statistics header parser
// Tracks the byte position, latches the header bytes of interest and
// classifies the frame from the bytes seen so far, including the current one.
// ----------------------------------------------------------------------------
module fps_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output fps_pkg::frame_class_t frame_class
);

    logic [fps_pkg::POS_W-1:0]      pos_reg;
    logic [fps_pkg::POS_W-1:0]      pos_next;
    logic [fps_pkg::OFS_W-1:0]      offset_reg;
    logic [fps_pkg::OFS_W-1:0]      offset_next;
    logic [fps_pkg::NUM_FIELDS-1:0] valid_reg;
    logic [fps_pkg::NUM_FIELDS-1:0] valid_next;
    logic [7:0]                     field_reg  [fps_pkg::NUM_FIELDS];
    logic [7:0]                     field_next [fps_pkg::NUM_FIELDS];
    logic                           is_ipv4;

    function automatic logic hit(input logic v, input logic [7:0] a, input logic [7:0] b);
        return v && (a == b);
    endfunction

    always_comb
    begin
        pos_next    = pos_reg;
        offset_next = offset_reg;
        valid_next  = valid_reg;
        field_next  = field_reg;
        if (pos_reg < fps_pkg::POS_W'(fps_pkg::MAX_FRAME_BYTES))
        begin
            unique case (pos_reg)
                fps_pkg::POS_W'(fps_pkg::POS_ETH_HI):
                begin
                    field_next[fps_pkg::F_ETH_HI] = data_byte;
                    valid_next[fps_pkg::F_ETH_HI] = 1'b1;
                end
                fps_pkg::POS_W'(fps_pkg::POS_ETH_LO):
                begin
                    field_next[fps_pkg::F_ETH_LO] = data_byte;
                    valid_next[fps_pkg::F_ETH_LO] = 1'b1;
                end
                fps_pkg::POS_W'(fps_pkg::POS_VHL):
                begin
                    field_next[fps_pkg::F_VHL] = data_byte;
                    valid_next[fps_pkg::F_VHL] = 1'b1;
                    offset_next = fps_pkg::OFS_W'(fps_pkg::POS_VHL)
                                + fps_pkg::OFS_W'({data_byte[3:0], 2'b00});
                end
                fps_pkg::POS_W'(fps_pkg::POS_LEN_HI):
                begin
                    field_next[fps_pkg::F_LEN_HI] = data_byte;
                    valid_next[fps_pkg::F_LEN_HI] = 1'b1;
                end
                fps_pkg::POS_W'(fps_pkg::POS_LEN_LO):
                begin
                    field_next[fps_pkg::F_LEN_LO] = data_byte;
                    valid_next[fps_pkg::F_LEN_LO] = 1'b1;
                end
                fps_pkg::POS_W'(fps_pkg::POS_ARP_OP):
                begin
                    field_next[fps_pkg::F_ARP_OP] = data_byte;
                    valid_next[fps_pkg::F_ARP_OP] = 1'b1;
                end
                fps_pkg::POS_W'(fps_pkg::POS_PROTO):
                begin
                    field_next[fps_pkg::F_PROTO] = data_byte;
                    valid_next[fps_pkg::F_PROTO] = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (pos_reg >= fps_pkg::POS_W'(fps_pkg::POS_VHL))
            begin
                if (pos_reg == fps_pkg::POS_W'(offset_next))
                begin
                    field_next[fps_pkg::F_ICMP] = data_byte;
                    valid_next[fps_pkg::F_ICMP] = 1'b1;
                end
                if (pos_reg == fps_pkg::POS_W'(offset_next)
                             + fps_pkg::POS_W'(fps_pkg::PORT_LO_SKIP))
                begin
                    field_next[fps_pkg::F_PORT] = data_byte;
                    valid_next[fps_pkg::F_PORT] = 1'b1;
                end
            end
            pos_next = pos_reg + fps_pkg::POS_W'(1);
        end
    end

    always_comb
    begin
        is_ipv4 = hit(valid_next[fps_pkg::F_ETH_HI], field_next[fps_pkg::F_ETH_HI],
                      fps_pkg::ETH_TYPE_HI)
               && hit(valid_next[fps_pkg::F_ETH_LO], field_next[fps_pkg::F_ETH_LO],
                      fps_pkg::ETH_LO_IPV4);
        frame_class.arp = hit(valid_next[fps_pkg::F_ETH_HI], field_next[fps_pkg::F_ETH_HI],
                              fps_pkg::ETH_TYPE_HI)
                       && hit(valid_next[fps_pkg::F_ETH_LO], field_next[fps_pkg::F_ETH_LO],
                              fps_pkg::ETH_LO_ARP);
        frame_class.arp_request = frame_class.arp
            && hit(valid_next[fps_pkg::F_ARP_OP], field_next[fps_pkg::F_ARP_OP],
                   fps_pkg::ARP_OP_REQUEST);
        frame_class.arp_reply = frame_class.arp && !frame_class.arp_request;
        frame_class.icmp = is_ipv4
            && hit(valid_next[fps_pkg::F_PROTO], field_next[fps_pkg::F_PROTO],
                   fps_pkg::PROTO_ICMP);
        frame_class.echo_request = frame_class.icmp
            && hit(valid_next[fps_pkg::F_ICMP], field_next[fps_pkg::F_ICMP],
                   fps_pkg::ICMP_ECHO_REQ);
        frame_class.echo_reply = frame_class.icmp
            && hit(valid_next[fps_pkg::F_ICMP], field_next[fps_pkg::F_ICMP],
                   fps_pkg::ICMP_ECHO_REP);
        frame_class.tcp = is_ipv4
            && hit(valid_next[fps_pkg::F_PROTO], field_next[fps_pkg::F_PROTO],
                   fps_pkg::PROTO_TCP);
        frame_class.http = frame_class.tcp
            && hit(valid_next[fps_pkg::F_PORT], field_next[fps_pkg::F_PORT],
                   fps_pkg::HTTP_PORT_LO);
        frame_class.udp = is_ipv4
            && hit(valid_next[fps_pkg::F_PROTO], field_next[fps_pkg::F_PROTO],
                   fps_pkg::PROTO_UDP);
        frame_class.total_length = {
            field_next[fps_pkg::F_LEN_HI] & {8{valid_next[fps_pkg::F_LEN_HI]}},
            field_next[fps_pkg::F_LEN_LO] & {8{valid_next[fps_pkg::F_LEN_LO]}}
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            offset_reg <= '0;
            valid_reg  <= '0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                pos_reg    <= '0;
                offset_reg <= '0;
                valid_reg  <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                offset_reg <= offset_next;
                valid_reg  <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            field_reg <= field_next;
        end
    end

endmodule

@@ design/fps_counters.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame protocol statistics counter bank
// Holds the wrapping statistics counters and the result register that
// presents them, with the length field, at the end of each frame.
// ----------------------------------------------------------------------------
module fps_counters (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_done,
    input  fps_pkg::frame_class_t frame_class,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [31:0]           frames_seen,
    output logic [31:0]           arp_frames,
    output logic [31:0]           arp_requests,
    output logic [31:0]           arp_replies,
    output logic [31:0]           icmp_packets,
    output logic [31:0]           icmp_echo_requests,
    output logic [31:0]           icmp_echo_replies,
    output logic [31:0]           tcp_segments,
    output logic [31:0]           udp_datagrams,
    output logic [31:0]           http_segments,
    output logic [15:0]           ip_total_length
);

    fps_pkg::counter_t               cnt_reg [fps_pkg::NUM_COUNTERS];
    fps_pkg::counter_t               cnt_next [fps_pkg::NUM_COUNTERS];
    logic [fps_pkg::NUM_COUNTERS-1:0] bump;
    logic                            out_valid_reg;
    logic [15:0]                     length_reg;

    always_comb
    begin
        bump                       = '0;
        bump[fps_pkg::C_FRAMES]    = 1'b1;
        bump[fps_pkg::C_ARP]       = frame_class.arp;
        bump[fps_pkg::C_ARP_REQ]   = frame_class.arp_request;
        bump[fps_pkg::C_ARP_REP]   = frame_class.arp_reply;
        bump[fps_pkg::C_ICMP]      = frame_class.icmp;
        bump[fps_pkg::C_ECHO_REQ]  = frame_class.echo_request;
        bump[fps_pkg::C_ECHO_REP]  = frame_class.echo_reply;
        bump[fps_pkg::C_TCP]       = frame_class.tcp;
        bump[fps_pkg::C_UDP]       = frame_class.udp;
        bump[fps_pkg::C_HTTP]      = frame_class.http;
        for (int k = 0; k < fps_pkg::NUM_COUNTERS; k++)
        begin
            cnt_next[k] = cnt_reg[k] + fps_pkg::COUNTER_BITS'(bump[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int k = 0; k < fps_pkg::NUM_COUNTERS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else if (frame_done)
        begin
            out_valid_reg <= 1'b1;
            cnt_reg       <= cnt_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            length_reg <= frame_class.total_length;
        end
    end

    assign out_valid          = out_valid_reg;
    assign frames_seen        = 32'(cnt_reg[fps_pkg::C_FRAMES]);
    assign arp_frames         = 32'(cnt_reg[fps_pkg::C_ARP]);
    assign arp_requests       = 32'(cnt_reg[fps_pkg::C_ARP_REQ]);
    assign arp_replies        = 32'(cnt_reg[fps_pkg::C_ARP_REP]);
    assign icmp_packets       = 32'(cnt_reg[fps_pkg::C_ICMP]);
    assign icmp_echo_requests = 32'(cnt_reg[fps_pkg::C_ECHO_REQ]);
    assign icmp_echo_replies  = 32'(cnt_reg[fps_pkg::C_ECHO_REP]);
    assign tcp_segments       = 32'(cnt_reg[fps_pkg::C_TCP]);
    assign udp_datagrams      = 32'(cnt_reg[fps_pkg::C_UDP]);
    assign http_segments      = 32'(cnt_reg[fps_pkg::C_HTTP]);
    assign ip_total_length    = length_reg;

`ifndef SYNTHESIS
    a_done_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> out_valid_reg)
        else $error("result not presented after frame end");

    a_frame_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> cnt_reg[fps_pkg::C_FRAMES]
                       == $past(cnt_reg[fps_pkg::C_FRAMES]) + fps_pkg::COUNTER_BITS'(1))
        else $error("frame counter did not advance by one");

    a_stall_holds_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(cnt_reg[fps_pkg::C_FRAMES])
                                        && $stable(length_reg))
        else $error("counters changed while the result was stalled");
`endif

endmodule

@@ design/frame_protocol_statistics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame protocol statistics
// Classifies received Ethernet frames and keeps per-protocol frame counters.
//
// The input channel (in_valid, in_ready, data_byte, last_byte) carries one
// frame byte per transaction, starting at the destination MAC; last_byte
// marks the final byte. One byte can be taken in every cycle while no
// frame end is held. The output channel (out_valid, out_ready and the
// counter fields) carries one transaction per frame, holding all counters
// after that frame and the IPv4 total-length field. Each byte is first
// held in the input register; the parse and the counter update happen as
// it leaves that register, and the result register is loaded with them.
// While a result is stalled by out_ready low, bytes that do not end a frame
// keep flowing; a second frame end holds in the input register until the
// result register is free, and in_ready drops only then.
// Reset clears the counters, the byte position and the header-byte valid
// flags; no clearing pass is needed, the block is ready right after reset.
// ----------------------------------------------------------------------------
module frame_protocol_statistics (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] frames_seen,
    output logic [31:0] arp_frames,
    output logic [31:0] arp_requests,
    output logic [31:0] arp_replies,
    output logic [31:0] icmp_packets,
    output logic [31:0] icmp_echo_requests,
    output logic [31:0] icmp_echo_replies,
    output logic [31:0] tcp_segments,
    output logic [31:0] udp_datagrams,
    output logic [31:0] http_segments,
    output logic [15:0] ip_total_length
);

    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    logic [7:0]            data_reg;
    logic                  last_reg;
    logic                  advance;
    logic                  frame_done;
    fps_pkg::frame_class_t frame_class;

    assign advance    = stage_valid_reg && (!last_reg || !out_valid || out_ready);
    assign frame_done = advance && last_reg;
    assign in_ready   = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_valid && in_ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    fps_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .data_byte   (data_reg),
        .last_byte   (last_reg),
        .frame_class (frame_class)
    );

    fps_counters u_counters (
        .clk                (clk),
        .rst_n              (rst_n),
        .frame_done         (frame_done),
        .frame_class        (frame_class),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .frames_seen        (frames_seen),
        .arp_frames         (arp_frames),
        .arp_requests       (arp_requests),
        .arp_replies        (arp_replies),
        .icmp_packets       (icmp_packets),
        .icmp_echo_requests (icmp_echo_requests),
        .icmp_echo_replies  (icmp_echo_replies),
        .tcp_segments       (tcp_segments),
        .udp_datagrams      (udp_datagrams),
        .http_segments      (http_segments),
        .ip_total_length    (ip_total_length)
    );

`ifndef SYNTHESIS
    a_stall_only_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> stage_valid_reg && last_reg && out_valid && !out_ready)
        else $error("input stalled without a blocked frame end");

    a_frame_end_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && last_reg && !out_valid |=> out_valid)
        else $error("frame end did not reach the result register");
`endif

endmodule
